/* src/slab_object_allocator_macros.svh */
// assertion macros for the slab object allocator
`ifndef SLAB_OBJECT_ALLOCATOR_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_MACROS_SVH

// checked only while out of reset
`define SOA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SOA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/soa_pkg.sv */
// shared constants and types of the slab object allocator
package soa_pkg;

    localparam int MAX_SLABS_DEF = 64;
    localparam int MAX_OBJS_DEF  = 256;

    localparam int SLAB_FIELD_W = 6;
    localparam int OBJ_FIELD_W  = 8;
    localparam int CFG_W        = 9;
    localparam int CNT_W        = 9;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 9'd511;
    localparam logic [CFG_W-1:0] CFG_RST_VAL = 9'd256;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // list codes, sentinel node is MAX_SLABS plus the code
    localparam logic [1:0] LST_FREE = 2'd0;
    localparam logic [1:0] LST_PART = 2'd1;
    localparam logic [1:0] LST_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD,
        ST_OBJ,
        ST_PUSH1,
        ST_PUSH2,
        ST_DONE
    } soa_state_t;

endpackage

/* src/soa_ram.sv */
// simple dual port ram, one write and one registered read per cycle
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/slab_object_allocator.sv */
// slab object allocator top level: request sequencer, list heads and state memories
//
//  channel  | dir | beat contents (low bits first)
//  s_*      | in  | tdata: free_slab[5:0], free_obj[13:6]; tuser: op
//  m_*      | out | tdata: got_slab[5:0], got_obj[13:6]; tuser: status
//  cfg_*    | in  | data: objs_per_slab
//
// one request at a time, paced by the single write port of the list link memories:
// alloc reads a slab, pops an object and pushes the slab on a list, first writing
// the object chain (up to 256 objects) of a slab it opens; a free reads and pushes
// only on a list change; a failed alloc or a free to an unopened slab skips the read.
// reset is synchronous, active low; the object memory needs no clearing pass.
// a result waiting on m_tready holds the sequencer in its final step only.
`include "slab_object_allocator_macros.svh"

module slab_object_allocator #(
    parameter int MAX_SLABS = soa_pkg::MAX_SLABS_DEF,
    parameter int MAX_OBJS  = soa_pkg::MAX_OBJS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // free_slab[5:0], free_obj[13:6], zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // got_slab[5:0], got_obj[13:6], zero pad
    output logic        m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [soa_pkg::CFG_W-1:0] cfg_data
);
    import soa_pkg::*;

    localparam int SW    = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int NW    = $clog2(MAX_SLABS + 4);
    localparam int OPW   = $clog2(MAX_SLABS + 1);
    localparam int OBJ_W = $clog2(MAX_OBJS + 1);
    localparam int OIX_W = (MAX_OBJS > 1) ? $clog2(MAX_OBJS) : 1;
    localparam int ODEP  = MAX_SLABS * MAX_OBJS;
    localparam int AW    = (ODEP > 1) ? $clog2(ODEP) : 1;
    localparam int RW    = 2 * OBJ_W + 2 * CNT_W;

    localparam logic [NW-1:0]    SENT_BASE = NW'(MAX_SLABS);
    localparam logic [OBJ_W-1:0] OBJ_NIL   = OBJ_W'(MAX_OBJS);

    soa_state_t state_reg, state_next;

    logic                    op_reg, op_next;
    logic [OBJ_FIELD_W-1:0]  fo_reg, fo_next;
    logic [SW-1:0]           s_reg, s_next;
    logic                    new_reg, new_next;
    logic [OBJ_W-1:0]        rh_reg, rh_next;
    logic [CNT_W-1:0]        rc_reg, rc_next;
    logic [CNT_W-1:0]        rn_reg, rn_next;
    logic [OBJ_W-1:0]        rw_reg, rw_next;
    logic [1:0]              tgt_reg, tgt_next;
    logic [OBJ_W-1:0]        o_reg, o_next;
    logic [OBJ_W-1:0]        ini_reg, ini_next;
    logic [OPW-1:0]          opened_reg, opened_next;
    logic [CFG_W-1:0]        ops_reg;
    logic [NW-1:0]           lhead_reg [3];
    logic [NW-1:0]           lhead_next [3];
    logic [NW-1:0]           ltail_reg [3];
    logic [NW-1:0]           ltail_next [3];

    logic [SLAB_FIELD_W-1:0] r_slab_reg, r_slab_next;
    logic [OBJ_FIELD_W-1:0]  r_obj_reg, r_obj_next;
    logic                    r_fail_reg, r_fail_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SLAB_FIELD_W-1:0] m_slab_reg, m_slab_next;
    logic [OBJ_FIELD_W-1:0]  m_obj_reg, m_obj_next;
    logic                    m_stat_reg, m_stat_next;

    // memory ports
    logic            rec_we;
    logic [SW-1:0]   rec_waddr, rec_raddr;
    logic [RW-1:0]   rec_wdata, rec_q;
    logic            nx_we;
    logic [SW-1:0]   nx_waddr, nx_raddr;
    logic [NW-1:0]   nx_wdata, nx_q;
    logic            pv_we;
    logic [SW-1:0]   pv_waddr, pv_raddr;
    logic [NW-1:0]   pv_wdata, pv_q;
    logic            ob_we;
    logic [AW-1:0]   ob_waddr, ob_raddr;
    logic [OBJ_W-1:0] ob_wdata, ob_q;

    // helpers
    logic [SLAB_FIELD_W-1:0] in_fs;
    logic [OBJ_FIELD_W-1:0]  in_fo;
    logic [CNT_W-1:0]        n_clamp;
    logic [OBJ_W-1:0]        cur_h, cur_w, new_h, new_w;
    logic [CNT_W-1:0]        cur_c, cur_n, c_dec, c_inc;
    logic [NW-1:0]           last_node;
    logic [31:0]             s_wide, o_wide;
    logic [2:0]              lst_head_empty, lst_tail_empty;

    soa_ram #(.WIDTH(RW), .DEPTH(MAX_SLABS)) u_rec (
        .aclk(aclk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_q)
    );
    soa_ram #(.WIDTH(NW), .DEPTH(MAX_SLABS)) u_next (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_q)
    );
    soa_ram #(.WIDTH(NW), .DEPTH(MAX_SLABS)) u_prev (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_q)
    );
    soa_ram #(.WIDTH(OBJ_W), .DEPTH(ODEP)) u_obj (
        .aclk(aclk), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
        .raddr(ob_raddr), .rdata(ob_q)
    );

    assign in_fs     = s_tdata[SLAB_FIELD_W-1:0];
    assign in_fo     = s_tdata[SLAB_FIELD_W+OBJ_FIELD_W-1:SLAB_FIELD_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_obj_reg, m_slab_reg};
    assign m_tuser   = m_stat_reg;

    always_comb begin
        if (ops_reg == '0) begin
            n_clamp = CNT_W'(1);
        end else if (32'(ops_reg) > MAX_OBJS) begin
            n_clamp = CNT_W'(MAX_OBJS);
        end else begin
            n_clamp = ops_reg;
        end
    end

    // record fields: new slab comes from registers, otherwise from memory
    always_comb begin
        if (new_reg) begin
            cur_h = rh_reg;
            cur_c = rc_reg;
            cur_n = rn_reg;
            cur_w = rw_reg;
        end else begin
            cur_h = rec_q[OBJ_W-1:0];
            cur_c = rec_q[OBJ_W+CNT_W-1:OBJ_W];
            cur_n = rec_q[OBJ_W+2*CNT_W-1:OBJ_W+CNT_W];
            cur_w = rec_q[RW-1:OBJ_W+2*CNT_W];
        end
        c_dec = (cur_c == '0) ? '0 : cur_c - CNT_W'(1);
        c_inc = (cur_c == COUNT_MAX) ? COUNT_MAX : cur_c + CNT_W'(1);
    end

    // head after pop: the low mark stays zero since a new slab's chain is written out
    always_comb begin
        new_h = rh_reg;
        new_w = rw_reg;
        if (rh_reg < OBJ_NIL) begin
            if (rh_reg < rw_reg) begin
                new_h = (rh_reg == '0) ? OBJ_NIL : rh_reg - OBJ_W'(1);
                new_w = rh_reg;
            end else begin
                new_h = ob_q;
            end
        end
    end

    assign last_node = ltail_reg[tgt_reg];
    assign s_wide    = 32'(s_reg);
    assign o_wide    = 32'(o_reg);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lst_head_empty[k] = (lhead_reg[k] == SENT_BASE + NW'(k));
            lst_tail_empty[k] = (ltail_reg[k] == SENT_BASE + NW'(k));
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        fo_next      = fo_reg;
        s_next       = s_reg;
        new_next     = new_reg;
        rh_next      = rh_reg;
        rc_next      = rc_reg;
        rn_next      = rn_reg;
        rw_next      = rw_reg;
        tgt_next     = tgt_reg;
        o_next       = o_reg;
        ini_next     = ini_reg;
        opened_next  = opened_reg;
        r_slab_next  = r_slab_reg;
        r_obj_next   = r_obj_reg;
        r_fail_next  = r_fail_reg;
        m_valid_next = m_valid_reg;
        m_slab_next  = m_slab_reg;
        m_obj_next   = m_obj_reg;
        m_stat_next  = m_stat_reg;
        for (int k = 0; k < 3; k++) begin
            lhead_next[k] = lhead_reg[k];
            ltail_next[k] = ltail_reg[k];
        end
        rec_we    = 1'b0;
        rec_waddr = s_reg;
        rec_wdata = '0;
        rec_raddr = s_reg;
        nx_we     = 1'b0;
        nx_waddr  = s_reg;
        nx_wdata  = '0;
        nx_raddr  = s_reg;
        pv_we     = 1'b0;
        pv_waddr  = s_reg;
        pv_wdata  = '0;
        pv_raddr  = s_reg;
        ob_we     = 1'b0;
        ob_waddr  = '0;
        ob_wdata  = cur_h;
        ob_raddr  = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next  = s_tuser;
                    fo_next  = in_fo;
                    new_next = 1'b0;
                    r_fail_next = STAT_OK;
                    if (s_tuser == OP_ALLOC) begin
                        if (lhead_reg[LST_FREE] != SENT_BASE + NW'(LST_FREE)) begin
                            s_next = SW'(lhead_reg[LST_FREE]);
                            state_next = ST_RD;
                        end else if (lhead_reg[LST_PART] != SENT_BASE + NW'(LST_PART)) begin
                            s_next = SW'(lhead_reg[LST_PART]);
                            state_next = ST_RD;
                        end else if (32'(opened_reg) >= MAX_SLABS) begin
                            r_slab_next = '0;
                            r_obj_next  = '0;
                            r_fail_next = STAT_FAIL;
                            state_next  = ST_DONE;
                        end else begin
                            // open the next pool slab, its object chain is written first
                            s_next      = SW'(opened_reg);
                            opened_next = opened_reg + OPW'(1);
                            new_next    = 1'b1;
                            rh_next     = OBJ_W'(n_clamp - CNT_W'(1));
                            rc_next     = n_clamp;
                            rn_next     = n_clamp;
                            rw_next     = '0;
                            ini_next    = '0;
                            state_next  = ST_INIT;
                        end
                    end else begin
                        s_next      = SW'(in_fs);
                        r_slab_next = in_fs;
                        r_obj_next  = in_fo;
                        if (32'(in_fs) < MAX_SLABS && 32'(in_fs) < 32'(opened_reg)) begin
                            state_next = ST_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    rec_raddr = s_next;
                    nx_raddr  = s_next;
                    pv_raddr  = s_next;
                end
            end

            ST_INIT: begin
                // object i links to i - 1, object 0 ends the chain
                ob_we    = 1'b1;
                ob_waddr = AW'(s_reg) * AW'(MAX_OBJS) + AW'(OIX_W'(ini_reg));
                ob_wdata = (ini_reg == '0) ? OBJ_NIL : ini_reg - OBJ_W'(1);
                ini_next = ini_reg + OBJ_W'(1);
                if (ini_reg == OBJ_W'(rn_reg - CNT_W'(1))) begin
                    state_next = ST_RD;
                end
            end

            ST_RD: begin
                if (op_reg == OP_ALLOC) begin
                    rh_next  = cur_h;
                    rc_next  = c_dec;
                    rn_next  = cur_n;
                    rw_next  = cur_w;
                    tgt_next = (c_dec == '0) ? LST_FULL : LST_PART;
                    o_next   = (cur_h < OBJ_NIL) ? cur_h : '0;
                    ob_raddr = AW'(s_reg) * AW'(MAX_OBJS) + AW'(OIX_W'(cur_h));
                    state_next = ST_OBJ;
                end else if (CNT_W'(fo_reg) >= cur_n) begin
                    state_next = ST_DONE;
                end else begin
                    ob_we     = 1'b1;
                    ob_waddr  = AW'(s_reg) * AW'(MAX_OBJS) + AW'(OIX_W'(fo_reg));
                    rec_we    = 1'b1;
                    rec_wdata = {cur_w, cur_n, c_inc, OBJ_W'(fo_reg)};
                    if (c_inc == cur_n) begin
                        tgt_next   = LST_FREE;
                        state_next = ST_PUSH1;
                    end else if (c_inc == CNT_W'(1)) begin
                        tgt_next   = LST_PART;
                        state_next = ST_PUSH1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
                // unlink from the current list when the slab is about to move
                if ((op_reg == OP_ALLOC && !new_reg) || state_next == ST_PUSH1) begin
                    if (pv_q >= SENT_BASE) begin
                        lhead_next[2'(pv_q - SENT_BASE)] = nx_q;
                    end else begin
                        nx_we    = 1'b1;
                        nx_waddr = SW'(pv_q);
                        nx_wdata = nx_q;
                    end
                    if (nx_q >= SENT_BASE) begin
                        ltail_next[2'(nx_q - SENT_BASE)] = pv_q;
                    end else begin
                        pv_we    = 1'b1;
                        pv_waddr = SW'(nx_q);
                        pv_wdata = pv_q;
                    end
                end
            end

            ST_OBJ: begin
                rec_we      = 1'b1;
                rec_wdata   = {new_w, rn_reg, rc_reg, new_h};
                r_slab_next = s_wide[SLAB_FIELD_W-1:0];
                r_obj_next  = o_wide[OBJ_FIELD_W-1:0];
                state_next  = ST_PUSH1;
            end

            ST_PUSH1: begin
                if (last_node == SENT_BASE + NW'(tgt_reg)) begin
                    lhead_next[tgt_reg] = NW'(s_reg);
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = SW'(last_node);
                    nx_wdata = NW'(s_reg);
                end
                ltail_next[tgt_reg] = NW'(s_reg);
                pv_we      = 1'b1;
                pv_waddr   = s_reg;
                pv_wdata   = last_node;
                state_next = ST_PUSH2;
            end

            ST_PUSH2: begin
                nx_we      = 1'b1;
                nx_waddr   = s_reg;
                nx_wdata   = SENT_BASE + NW'(tgt_reg);
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_slab_next  = r_slab_reg;
                    m_obj_next   = r_obj_reg;
                    m_stat_next  = r_fail_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            opened_reg  <= '0;
            ops_reg     <= CFG_RST_VAL;
            m_valid_reg <= 1'b0;
            new_reg     <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                lhead_reg[k] <= SENT_BASE + NW'(k);
                ltail_reg[k] <= SENT_BASE + NW'(k);
            end
        end else begin
            state_reg   <= state_next;
            opened_reg  <= opened_next;
            m_valid_reg <= m_valid_next;
            new_reg     <= new_next;
            if (cfg_valid && cfg_ready) begin
                ops_reg <= cfg_data;
            end
            for (int k = 0; k < 3; k++) begin
                lhead_reg[k] <= lhead_next[k];
                ltail_reg[k] <= ltail_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        fo_reg     <= fo_next;
        s_reg      <= s_next;
        rh_reg     <= rh_next;
        rc_reg     <= rc_next;
        rn_reg     <= rn_next;
        rw_reg     <= rw_next;
        tgt_reg    <= tgt_next;
        o_reg      <= o_next;
        ini_reg    <= ini_next;
        r_slab_reg <= r_slab_next;
        r_obj_reg  <= r_obj_next;
        r_fail_reg <= r_fail_next;
        m_slab_reg <= m_slab_next;
        m_obj_reg  <= m_obj_next;
        m_stat_reg <= m_stat_next;
    end

    `SOA_ASSERT(a_fail_only_when_exhausted,
        (m_valid_reg && m_stat_reg == STAT_FAIL) |-> (32'(opened_reg) == MAX_SLABS),
        "alloc failure reported while pool slabs remain")
    `SOA_ASSERT(a_list_ends_agree, lst_head_empty == lst_tail_empty,
        "list head and tail disagree on emptiness")
    `SOA_ASSERT(a_opened_monotonic, 1'b1 |=> (opened_reg >= $past(opened_reg)),
        "opened slab count went down")
    `SOA_ASSERT_RST(a_reset_clears_pool, !aresetn |=> (opened_reg == '0 && !m_valid_reg),
        "reset did not clear the slab pool")

endmodule

/* tb/sv/slab_object_allocator_checker.sv */
// result checker for the slab object allocator: watches the request, result and config channels and predicts results
module slab_object_allocator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    import soa_pkg::*;

    localparam int NSLAB = MAX_SLABS_DEF;
    localparam int NOBJ  = MAX_OBJS_DEF;
    localparam int NODE_NIL = NSLAB + 3;
    localparam int OBJ_NIL  = NOBJ;
    localparam int SENT_FREE = NSLAB + int'(LST_FREE);
    localparam int SENT_PART = NSLAB + int'(LST_PART);
    localparam int SENT_FULL = NSLAB + int'(LST_FULL);

    typedef struct packed {
        logic [5:0] slab;
        logic [7:0] obj;
        logic       status;
    } grant_t;

    grant_t grants_due[$];

    logic [8:0] objs_cfg;
    int chain[NSLAB*NOBJ];
    int head[NSLAB];
    int free_cnt[NSLAB];
    int nobj[NSLAB];
    int lnext[NSLAB+3];
    int lprev[NSLAB+3];
    int opened;

    assign pending = grants_due.size();

    function automatic void detach(int s);
        int p, n;
        p = lprev[s];
        n = lnext[s];
        if (p >= NSLAB + 3 || n >= NSLAB + 3) return;
        lnext[p] = n;
        lprev[n] = p;
        lprev[s] = NODE_NIL;
        lnext[s] = NODE_NIL;
    endfunction

    function automatic void append(int sent, int s);
        int last;
        last = lprev[sent];
        lnext[last] = s;
        lprev[sent] = s;
        lprev[s] = last;
        lnext[s] = sent;
    endfunction

    function automatic int take_front(int sent);
        int s;
        s = lnext[sent];
        if (s == sent || s >= NSLAB) return NODE_NIL;
        detach(s);
        return s;
    endfunction

    function automatic void clear_model();
        objs_cfg = CFG_RST_VAL;
        foreach (head[i]) begin
            head[i] = 0;
            free_cnt[i] = 0;
            nobj[i] = 0;
        end
        foreach (lnext[i]) begin
            lnext[i] = (i >= NSLAB) ? i : NODE_NIL;
            lprev[i] = (i >= NSLAB) ? i : NODE_NIL;
        end
        opened = 0;
    endfunction

    function automatic grant_t serve(logic op, int fs, int fo);
        grant_t g;
        int s, o, n;
        g.status = STAT_OK;
        if (op == OP_ALLOC) begin
            s = take_front(SENT_FREE);
            if (s == NODE_NIL) s = take_front(SENT_PART);
            if (s == NODE_NIL) begin
                if (opened >= NSLAB) begin
                    g.slab = '0;
                    g.obj = '0;
                    g.status = STAT_FAIL;
                    return g;
                end
                s = opened++;
                n = int'(objs_cfg);
                if (n < 1) n = 1;
                if (n > NOBJ) n = NOBJ;
                nobj[s] = n;
                free_cnt[s] = n;
                for (int i = 0; i < n; i++) chain[s*NOBJ+i] = (i == 0) ? OBJ_NIL : i - 1;
                head[s] = n - 1;
                lnext[s] = NODE_NIL;
                lprev[s] = NODE_NIL;
            end
            o = head[s];
            if (o < NOBJ) head[s] = chain[s*NOBJ+o];
            else o = 0;
            if (free_cnt[s] > 0) free_cnt[s]--;
            append(free_cnt[s] == 0 ? SENT_FULL : SENT_PART, s);
            g.slab = 6'(s);
            g.obj = 8'(o);
            return g;
        end
        g.slab = 6'(fs);
        g.obj = 8'(fo);
        if (fs >= opened || fo >= nobj[fs]) return g;
        if (free_cnt[fs] < int'(COUNT_MAX)) free_cnt[fs]++;
        chain[fs*NOBJ+fo] = head[fs];
        head[fs] = fo;
        if (free_cnt[fs] == nobj[fs]) begin
            detach(fs);
            append(SENT_FREE, fs);
        end else if (free_cnt[fs] == 1) begin
            detach(fs);
            append(SENT_PART, fs);
        end
        return g;
    endfunction

    initial begin
        fail_count = 0;
        clear_model();
    end

    always @(posedge aclk) begin
        grant_t want, seen;
        if (!aresetn) begin
            clear_model();
            grants_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) objs_cfg = cfg_data;
            if (s_tvalid && s_tready)
                grants_due.push_back(serve(s_tuser, int'(s_tdata[5:0]),
                                           int'(s_tdata[13:6])));
            if (m_tvalid && m_tready) begin
                seen.slab = m_tdata[5:0];
                seen.obj = m_tdata[13:6];
                seen.status = m_tuser;
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected beat slab %0d obj %0d status %0d",
                             $time, seen.slab, seen.obj, seen.status);
                    fail_count++;
                end else begin
                    want = grants_due.pop_front();
                    if (want != seen || m_tdata[15:14] != 2'b00) begin
                        $display({"%0t: expected slab %0d obj %0d status %0d, ",
                                  "got slab %0d obj %0d status %0d"},
                                 $time, want.slab, want.obj, want.status,
                                 seen.slab, seen.obj, seen.status);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/slab_object_allocator_test.sv */
// top of the slab object allocator testbench: stimulus, idling phases and verdict
module slab_object_allocator_test;
    import soa_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = 0;
    int          fail_count;
    int          pending;

    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_recv = 0;
    int  quiet = 0;
    bit  timed_out = 0;
    int  objs_now = 256;

    slab_object_allocator DUT (.*);

    slab_object_allocator_checker u_check (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (hold_recv) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000 && !timed_out) begin
            timed_out = 1;
            $display("** slab_object_allocator: FAILED **");
            $finish;
        end
    end

    // valid stays up between beats unless the sender idles
    task automatic send_beat(logic op, logic [5:0] sl, logic [7:0] ob);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {2'b00, ob, sl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_objs(logic [8:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        objs_now = (v == 0) ? 1 : ((v > 256) ? 256 : int'(v));
    endtask

    task automatic alloc();
        send_beat(OP_ALLOC, 6'($urandom), 8'($urandom));
    endtask

    // frees an object at a random slab and index, mostly an index inside the slab size
    task automatic free_some();
        int k;
        logic [13:0] h;
        k = $urandom_range(9);
        if (k == 0) send_beat(OP_FREE, 6'($urandom), 8'($urandom));
        else begin
            // mostly: pick a random slab and an object index inside the configured slab size
            h = {8'($urandom_range(objs_now - 1)), 6'($urandom_range(63))};
            send_beat(OP_FREE, h[5:0], h[13:6]);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: large slab, free to unopened slab, bad index, refill and double free
        alloc();
        alloc();
        send_beat(OP_FREE, 6'd0, 8'd255);
        send_beat(OP_FREE, 6'd0, 8'd254);
        send_beat(OP_FREE, 6'd63, 8'd0);
        send_beat(OP_FREE, 6'd0, 8'd255);
        send_beat(OP_FREE, 6'd0, 8'd255);
        alloc();
        alloc();
        alloc();
        write_objs(9'd0);
        repeat (3) alloc();
        send_beat(OP_FREE, 6'd1, 8'd0);
        send_beat(OP_FREE, 6'd2, 8'd1);
        send_beat(OP_FREE, 6'd2, 8'd0);
        write_objs(9'd511);
        alloc();
        write_objs(9'd1);
        // exhaust the pool and see out of slabs
        repeat (64) alloc();
        send_beat(OP_FREE, 6'd40, 8'd0);
        alloc();
        alloc();

        // random phases with all idling mixes, slab sizes small mostly
        for (int ph = 0; ph < 8; ph++) begin
            send_idle  = (ph % 4 == 1 || ph % 4 == 3) ? 57 : 0;
            recv_stall = (ph % 4 == 2) ? 57 : 0;
            if (ph % 4 == 3) begin
                send_idle = 14;
                recv_stall = 14;
            end
            write_objs(ph == 7 ? 9'd256 : 9'($urandom_range(1, 8)));
            if (ph == 2) begin
                fork
                    begin
                        hold_recv = 1;
                        repeat (200) @(posedge aclk);
                        hold_recv = 0;
                    end
                    repeat (6) alloc();
                join
            end
            for (int i = 0; i < 105; i++) begin
                if ($urandom_range(99) < 55) alloc();
                else free_some();
            end
            drain();
        end
        send_beat(OP_FREE, 6'h2a, 8'h55);
        send_beat(OP_FREE, 6'h15, 8'haa);
        drain();
        if (fail_count == 0) $display("** slab_object_allocator: PASSED **");
        else $display("** slab_object_allocator: FAILED **");
        $finish;
    end
endmodule
